@@ rtl/arp_rsp_pkg.sv @@
// Shared types and constants for the ARP reply responder.
// Depends on nothing; the module files of the block refer to it by scoped names.
`default_nettype none

package arp_rsp_pkg;

    // Frame layout.
    localparam int unsigned HDR_BYTES = 42;
    localparam logic [5:0]  HDR_LEN   = 6'(HDR_BYTES);
    localparam logic [5:0]  LAST_POS  = 6'(HDR_BYTES - 1);

    // Fixed protocol values.
    localparam logic [15:0] ETYPE_ARP      = 16'h0806;
    localparam logic [7:0]  HW_ADDR_LEN    = 8'd6;
    localparam logic [7:0]  PROTO_ADDR_LEN = 8'd4;
    localparam logic [15:0] OPCODE_REPLY   = 16'h0002;

    // Configuration registers.
    localparam int unsigned CFG_DATA_W    = 48;
    localparam int unsigned CFG_INDEX_W   = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOCAL_MAC = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOCAL_IP  = 1'd1;
    localparam logic [47:0] LOCAL_MAC_RESET = 48'h0050_5633_1cca;
    localparam logic [31:0] LOCAL_IP_RESET  = 32'hc0a8_02d9;

    // Default number of pending replies between the front and back parts.
    localparam int unsigned QUEUE_DEPTH_DEFAULT = 2;

    // Header fields that a reply needs, captured from one request frame.
    typedef struct packed {
        logic [47:0] src_mac;   // bytes 6..11
        logic [47:0] types;     // bytes 12..17: ethertype, hardware and protocol type
        logic [47:0] req_mac;   // bytes 22..27: sender MAC of the request
        logic [31:0] req_ip;    // bytes 28..31: sender IP of the request
        logic [31:0] tgt_ip;    // bytes 38..41: target IP of the request
    } job_t;

    // Queue status seen by the front part.
    typedef struct packed {
        logic room_one;   // at least one free slot
        logic room_two;   // at least two free slots
        logic not_empty;  // a reply job is waiting
    } q_status_t;

endpackage

`default_nettype wire

@@ rtl/arp_rsp_rx_if.sv @@
// Receive channel: one frame byte per word with an end-of-frame mark.
// Depends on nothing.
`default_nettype none

interface arp_rsp_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       rx_last;

    modport source (output valid, output rx_byte, output rx_last, input ready);
    modport sink   (input valid, input rx_byte, input rx_last, output ready);
endinterface

`default_nettype wire

@@ rtl/arp_rsp_tx_if.sv @@
// Transmit channel: one reply byte per word with an end-of-frame mark.
// Depends on nothing.
`default_nettype none

interface arp_rsp_tx_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       tx_last;

    modport source (output valid, output tx_byte, output tx_last, input ready);
    modport sink   (input valid, input tx_byte, input tx_last, output ready);
endinterface

`default_nettype wire

@@ rtl/arp_rsp_queue.sv @@
// Small queue of reply jobs between the capture front and the reply back part.
// Depends on arp_rsp_pkg.
`default_nettype none

module arp_rsp_queue #(
    parameter int unsigned DEPTH = arp_rsp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire arp_rsp_pkg::job_t     push_job,
    input  wire logic                  pop,
    output arp_rsp_pkg::job_t          head,
    output arp_rsp_pkg::q_status_t     status
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_MAX = PTR_W'(DEPTH - 1);

    arp_rsp_pkg::job_t slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_MAX) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_MAX) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign head             = slot_reg[rd_ptr_reg];
    assign status.room_one  = (count_reg < CNT_W'(DEPTH));
    assign status.room_two  = (count_reg < CNT_W'(DEPTH - 1));
    assign status.not_empty = (count_reg != '0);

endmodule

`default_nettype wire

@@ rtl/arp_rsp_front.sv @@
// Front part: takes frame bytes, captures the header fields a reply needs and
// decides at the end of each frame whether a reply job goes to the queue.
// Depends on arp_rsp_pkg and arp_rsp_rx_if.
`default_nettype none

module arp_rsp_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    arp_rsp_rx_if.sink                 rx,
    input  wire logic [31:0]           local_ip,
    input  wire arp_rsp_pkg::q_status_t q_status,
    output logic                       push,
    output arp_rsp_pkg::job_t          push_job
);

    logic [5:0]        pos_reg, pos_next;
    logic              eval_reg, eval_next;
    arp_rsp_pkg::job_t cap_reg;
    logic              accept;
    logic              match;

    // A frame end that may push needs a free slot beyond the job still being judged.
    assign rx.ready = eval_reg ? q_status.room_two : q_status.room_one;
    assign accept   = rx.valid && rx.ready;

    always_comb
    begin
        pos_next  = pos_reg;
        eval_next = 1'b0;
        if (accept)
        begin
            if (pos_reg < arp_rsp_pkg::HDR_LEN)
            begin
                pos_next = pos_reg + 1'b1;
            end
            if (rx.rx_last)
            begin
                pos_next  = '0;
                eval_next = (pos_reg >= arp_rsp_pkg::LAST_POS);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            eval_reg <= 1'b0;
        end
        else
        begin
            pos_reg  <= pos_next;
            eval_reg <= eval_next;
        end
    end

    // Each captured byte sits at a fixed frame position.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int k = 0; k < 6; k++)
            begin
                if (pos_reg == 6'(6 + k))
                begin
                    cap_reg.src_mac[8*(5-k) +: 8] <= rx.rx_byte;
                end
                if (pos_reg == 6'(12 + k))
                begin
                    cap_reg.types[8*(5-k) +: 8] <= rx.rx_byte;
                end
                if (pos_reg == 6'(22 + k))
                begin
                    cap_reg.req_mac[8*(5-k) +: 8] <= rx.rx_byte;
                end
            end
            for (int k = 0; k < 4; k++)
            begin
                if (pos_reg == 6'(28 + k))
                begin
                    cap_reg.req_ip[8*(3-k) +: 8] <= rx.rx_byte;
                end
                if (pos_reg == 6'(38 + k))
                begin
                    cap_reg.tgt_ip[8*(3-k) +: 8] <= rx.rx_byte;
                end
            end
        end
    end

    // The check runs in the cycle after the last byte. A following frame cannot
    // disturb the captured fields yet, since it only reaches byte zero by then.
    assign match = (cap_reg.types[47:32] == arp_rsp_pkg::ETYPE_ARP) &&
                   (cap_reg.tgt_ip == local_ip);
    assign push     = eval_reg && match;
    assign push_job = cap_reg;

endmodule

`default_nettype wire

@@ rtl/arp_rsp_back.sv @@
// Back part: turns each queued reply job into 42 reply bytes through an output register.
// Depends on arp_rsp_pkg and arp_rsp_tx_if.
`default_nettype none

module arp_rsp_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire arp_rsp_pkg::job_t      job,
    input  wire arp_rsp_pkg::q_status_t q_status,
    input  wire logic [47:0]            local_mac,
    output logic                        pop,
    arp_rsp_tx_if.source                tx
);

    logic [5:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       last_reg, last_next;
    logic       advance;
    logic       load;
    logic [7:0] reply_byte;

    function automatic logic [7:0] byte_of48(input logic [47:0] v, input logic [2:0] k);
        logic [47:0] s;
        s = v >> (6'd40 - {k, 3'b000});
        return s[7:0];
    endfunction

    function automatic logic [7:0] byte_of32(input logic [31:0] v, input logic [1:0] k);
        logic [31:0] s;
        s = v >> (5'd24 - {k, 3'b000});
        return s[7:0];
    endfunction

    always_comb
    begin
        unique case (idx_reg) inside
            [6'd0:6'd5]:   reply_byte = byte_of48(job.src_mac, 3'(idx_reg));
            [6'd6:6'd11]:  reply_byte = byte_of48(local_mac, 3'(idx_reg - 6'd6));
            [6'd12:6'd17]: reply_byte = byte_of48(job.types, 3'(idx_reg - 6'd12));
            6'd18:         reply_byte = arp_rsp_pkg::HW_ADDR_LEN;
            6'd19:         reply_byte = arp_rsp_pkg::PROTO_ADDR_LEN;
            6'd20:         reply_byte = arp_rsp_pkg::OPCODE_REPLY[15:8];
            6'd21:         reply_byte = arp_rsp_pkg::OPCODE_REPLY[7:0];
            [6'd22:6'd27]: reply_byte = byte_of48(local_mac, 3'(idx_reg - 6'd22));
            [6'd28:6'd31]: reply_byte = byte_of32(job.tgt_ip, 2'(idx_reg - 6'd28));
            [6'd32:6'd37]: reply_byte = byte_of48(job.req_mac, 3'(idx_reg - 6'd32));
            [6'd38:6'd41]: reply_byte = byte_of32(job.req_ip, 2'(idx_reg - 6'd38));
            default:       reply_byte = '0;
        endcase
    end

    assign advance = !valid_reg || tx.ready;
    assign load    = advance && q_status.not_empty;
    assign pop     = load && (idx_reg == arp_rsp_pkg::LAST_POS);

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        if (load)
        begin
            valid_next = 1'b1;
            byte_next  = reply_byte;
            last_next  = (idx_reg == arp_rsp_pkg::LAST_POS);
            idx_next   = (idx_reg == arp_rsp_pkg::LAST_POS) ? '0 : idx_reg + 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        last_reg <= last_next;
    end

    assign tx.valid   = valid_reg;
    assign tx.tx_byte = byte_reg;
    assign tx.tx_last = last_reg;

endmodule

`default_nettype wire

@@ rtl/arp_rsp_queue_wrap_note.sv @@
// Configuration register bank for the local MAC and IP addresses.
// Depends on arp_rsp_pkg.
`default_nettype none

module arp_rsp_cfg (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_we,
    input  wire logic [arp_rsp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [arp_rsp_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic [47:0]                                local_mac,
    output logic [31:0]                                local_ip
);

    logic [47:0] mac_reg;
    logic [31:0] ip_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mac_reg <= arp_rsp_pkg::LOCAL_MAC_RESET;
            ip_reg  <= arp_rsp_pkg::LOCAL_IP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                arp_rsp_pkg::CFG_LOCAL_MAC: mac_reg <= cfg_data[47:0];
                arp_rsp_pkg::CFG_LOCAL_IP:  ip_reg  <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    assign local_mac = mac_reg;
    assign local_ip  = ip_reg;

endmodule

`default_nettype wire

@@ rtl/arp_reply_responder_unit.sv @@
// Top level of the ARP reply responder.
// Depends on arp_rsp_pkg, both channel interfaces, and the cfg, queue, front and back modules.
//
// The rx channel carries a received Ethernet frame, one byte per word, with
// rx_last on the final byte. The tx channel carries 42-byte ARP replies, one
// byte per word, with tx_last on the 42nd byte. A frame gets a reply when it
// held at least 42 bytes, its ethertype is ARP, and its target IP equals
// local_ip; the request opcode is not looked at. Other frames are dropped.
// The configuration port writes local_mac (index 0) or local_ip (index 1)
// with cfg_we; writes are meant to happen while no reply is pending.
//
// Input rate is one byte per cycle while rx.ready is high. The frame end is
// judged in the cycle after its last byte; a matching job enters the queue. A
// reply then streams at one byte per cycle while tx.ready is high, limited by
// the single output register of the reply serializer. Up to QUEUE_DEPTH judged
// replies wait between the two parts. If tx stalls, the output register holds
// its word and the queue fills; rx.ready drops when the queue is full, or has
// under two free slots while a frame end is judged; rx otherwise keeps going.
// Reset empties the queue, clears the output register and starts a new frame;
// the addresses return to their defaults. Nothing needs a clearing pass.
`default_nettype none

module arp_reply_responder_unit #(
    parameter int unsigned QUEUE_DEPTH = arp_rsp_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    arp_rsp_rx_if.sink                               rx,
    arp_rsp_tx_if.source                             tx,
    input  wire logic                                cfg_we,
    input  wire logic [arp_rsp_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [arp_rsp_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic [47:0]            local_mac;
    logic [31:0]            local_ip;
    logic                   push;
    logic                   pop;
    arp_rsp_pkg::job_t      push_job;
    arp_rsp_pkg::job_t      head_job;
    arp_rsp_pkg::q_status_t q_status;

    // Address registers; both parts read them live.
    arp_rsp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .local_mac (local_mac),
        .local_ip  (local_ip)
    );

    // Capture and classification of request frames.
    arp_rsp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .rx       (rx),
        .local_ip (local_ip),
        .q_status (q_status),
        .push     (push),
        .push_job (push_job)
    );

    // Accepted requests wait here so that rx and tx stall independently.
    arp_rsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head_job),
        .status   (q_status)
    );

    // Reply serializer; pops a job when its last byte is loaded.
    arp_rsp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job       (head_job),
        .q_status  (q_status),
        .local_mac (local_mac),
        .pop       (pop),
        .tx        (tx)
    );

endmodule

`default_nettype wire
